/* hw/rtl/cse_pkg.sv */
// Shared constants, entry type and field extraction helpers for the signal scaler.
package cse_pkg;

    localparam int NUM_ENTRIES_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int SLOT_W  = 4;
    localparam int ID_W    = 29;
    localparam int DATA_W  = 64;
    localparam int MUX_W   = 9;
    localparam int HSPEC_W = 10;
    localparam int LSPEC_W = 9;
    localparam int RAWIN_W = 16;
    localparam int OUTE_W  = 32;
    localparam int TAG_W   = 16;
    localparam int VAL_W   = 48;
    localparam int RAW_W   = 16;

    // item kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_LOAD  = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [MUX_W-1:0]   mux;
        logic [HSPEC_W-1:0] high;
        logic [LSPEC_W-1:0] low;
        logic [TAG_W-1:0]   tag;
        logic               fault;
    } t_entry_fix;

    function automatic logic [3:0] field_width(input logic [8:0] spec);
        logic [2:0] lo;
        logic [2:0] hi;
        lo = spec[5:3];
        hi = spec[2:0];
        field_width = (hi >= lo) ? 4'(hi - lo) + 4'd1 : 4'd0;
    endfunction

    function automatic logic [7:0] field_value(input logic [DATA_W-1:0] data,
                                               input logic [8:0] spec);
        logic [7:0] byte_v;
        logic [3:0] w;
        logic [8:0] mask;
        byte_v = data[8*spec[8:6] +: 8];
        w      = field_width(spec);
        mask   = (9'd1 << w) - 9'd1;
        field_value = (byte_v >> spec[5:3]) & mask[7:0];
    endfunction

    function automatic logic [RAW_W-1:0] raw_value(input logic [DATA_W-1:0] data,
                                                   input logic [HSPEC_W-1:0] hs,
                                                   input logic [LSPEC_W-1:0] ls);
        logic [RAW_W-1:0] hv;
        hv = hs[9] ? RAW_W'(field_value(data, hs[8:0])) : '0;
        raw_value = (hv << field_width(ls)) + RAW_W'(field_value(data, ls));
    endfunction

endpackage

/* hw/rtl/cse_if.sv */
// Item channel interfaces: input items and result items.
interface cse_in_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [cse_pkg::SLOT_W-1:0]      slot;
    logic [cse_pkg::ID_W-1:0]        frame_id;
    logic [cse_pkg::DATA_W-1:0]      payload;
    logic [cse_pkg::MUX_W-1:0]       mux_spec;
    logic [cse_pkg::HSPEC_W-1:0]     high_spec;
    logic [cse_pkg::LSPEC_W-1:0]     low_spec;
    logic [cse_pkg::RAWIN_W-1:0]     in_low;
    logic [cse_pkg::RAWIN_W-1:0]     in_high;
    logic signed [cse_pkg::OUTE_W-1:0] out_low;
    logic signed [cse_pkg::OUTE_W-1:0] out_high;
    logic [cse_pkg::TAG_W-1:0]       curve_tag;

    modport source (output valid, kind, slot, frame_id, payload, mux_spec, high_spec,
                    low_spec, in_low, in_high, out_low, out_high, curve_tag,
                    input ready);
    modport sink   (input valid, kind, slot, frame_id, payload, mux_spec, high_spec,
                    low_spec, in_low, in_high, out_low, out_high, curve_tag,
                    output ready);
endinterface

interface cse_out_if;
    logic                              valid;
    logic                              ready;
    logic [cse_pkg::TAG_W-1:0]         result_tag;
    logic signed [cse_pkg::VAL_W-1:0]  value;
    logic                              saturated;
    logic                              range_fault;
    logic                              last;

    modport source (output valid, result_tag, value, saturated, range_fault, last,
                    input ready);
    modport sink   (input valid, result_tag, value, saturated, range_fault, last,
                    output ready);
endinterface

/* hw/rtl/cse_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
module cse_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;

    always_comb begin
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_ge    = w_trial >= {1'b0, r_den};
        n_rem   = w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
        n_num   = {r_num[NUM_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
endmodule

/* hw/rtl/cse_cell.sv */
// One table cell: holds an entry, tests a frame, passes its contents down the ring.
module cse_cell #(
    parameter int GAIN_W = 49,
    parameter int OFF_W  = 66
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_rot,
    input  logic                        i_probe,
    input  logic [cse_pkg::ID_W-1:0]    i_fid,
    input  logic [7:0]                  i_byte0,
    input  cse_pkg::t_entry_fix         i_ld_fix,
    input  logic signed [GAIN_W-1:0]    i_ld_gain,
    input  logic signed [OFF_W-1:0]     i_ld_off,
    input  logic                        i_nb_valid,
    input  logic                        i_nb_match,
    input  cse_pkg::t_entry_fix         i_nb_fix,
    input  logic signed [GAIN_W-1:0]    i_nb_gain,
    input  logic signed [OFF_W-1:0]     i_nb_off,
    output logic                        o_valid,
    output logic                        o_match,
    output cse_pkg::t_entry_fix         o_fix,
    output logic signed [GAIN_W-1:0]    o_gain,
    output logic signed [OFF_W-1:0]     o_off
);
    logic                      r_valid;
    logic                      r_match;
    cse_pkg::t_entry_fix       r_fix;
    logic signed [GAIN_W-1:0]  r_gain;
    logic signed [OFF_W-1:0]   r_off;
    logic                      w_hit;

    assign w_hit = r_valid && (r_fix.id == i_fid)
                   && (!r_fix.mux[8] || (r_fix.mux[7:0] == i_byte0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_rot) begin
            r_valid <= i_nb_valid;
            r_match <= i_nb_match;
        end else if (i_probe) begin
            r_match <= w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_fix  <= i_ld_fix;
            r_gain <= i_ld_gain;
            r_off  <= i_ld_off;
        end else if (i_rot) begin
            r_fix  <= i_nb_fix;
            r_gain <= i_nb_gain;
            r_off  <= i_nb_off;
        end
    end

    assign o_valid = r_valid;
    assign o_match = r_match;
    assign o_fix   = r_fix;
    assign o_gain  = r_gain;
    assign o_off   = r_off;
endmodule

/* hw/rtl/cse_pipe.sv */
// Result pipeline: field extraction, split multiply, offset add, saturation.
module cse_pipe #(
    parameter int GAIN_W = 49,
    parameter int OFF_W  = 66,
    parameter int ACC_W  = 67
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  cse_pkg::t_entry_fix            i_fix,
    input  logic signed [GAIN_W-1:0]       i_gain,
    input  logic signed [OFF_W-1:0]        i_off,
    input  logic                           i_last,
    input  logic [cse_pkg::DATA_W-1:0]     i_payload,
    output logic                           o_vld,
    output logic [cse_pkg::TAG_W-1:0]      o_tag,
    output logic signed [cse_pkg::VAL_W-1:0] o_value,
    output logic                           o_sat,
    output logic                           o_fault,
    output logic                           o_last
);
    localparam int HI_W = GAIN_W - 32;
    localparam int VW   = cse_pkg::VAL_W;

    // stage 1: captured entry and frame data
    logic                         r1_vld;
    cse_pkg::t_entry_fix          r1_fix;
    logic signed [GAIN_W-1:0]     r1_gain;
    logic signed [OFF_W-1:0]      r1_off;
    logic                         r1_last;
    logic [cse_pkg::DATA_W-1:0]   r1_data;
    // stage 2: raw value
    logic                         r2_vld;
    logic [cse_pkg::TAG_W-1:0]    r2_tag;
    logic                         r2_fault, r2_last;
    logic signed [GAIN_W-1:0]     r2_gain;
    logic signed [OFF_W-1:0]      r2_off;
    logic [cse_pkg::RAW_W-1:0]    r2_raw;
    // stage 3: partial products
    logic                         r3_vld;
    logic [cse_pkg::TAG_W-1:0]    r3_tag;
    logic                         r3_fault, r3_last;
    logic [47:0]                  r3_plo;
    logic signed [HI_W+16:0]      r3_phi;
    logic signed [OFF_W-1:0]      r3_off;
    // stage 4: sum
    logic                         r4_vld;
    logic [cse_pkg::TAG_W-1:0]    r4_tag;
    logic                         r4_fault, r4_last;
    logic signed [ACC_W-1:0]      r4_acc;
    // output
    logic                         r_vld;
    logic [cse_pkg::TAG_W-1:0]    r_tag;
    logic signed [VW-1:0]         r_value;
    logic                         r_sat, r_fault, r_last;

    logic signed [ACC_W-1:0]      w_hi, w_lo, w_off, n_acc;
    logic                         w_fits;
    logic signed [HI_W-1:0]       w_ghi;

    assign w_ghi = r2_gain[GAIN_W-1:32];

    always_comb begin
        w_hi   = ACC_W'(r3_phi);
        w_lo   = ACC_W'({1'b0, r3_plo});
        w_off  = ACC_W'(r3_off);
        n_acc  = (w_hi <<< 32) + w_lo + w_off;
        w_fits = (r4_acc[ACC_W-1:VW-1] == '0) || (r4_acc[ACC_W-1:VW-1] == '1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r_vld  <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r_vld  <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_fix   <= i_fix;
            r1_gain  <= i_gain;
            r1_off   <= i_off;
            r1_last  <= i_last;
            r1_data  <= i_payload;

            r2_tag   <= r1_fix.tag;
            r2_fault <= r1_fix.fault;
            r2_last  <= r1_last;
            r2_gain  <= r1_gain;
            r2_off   <= r1_off;
            r2_raw   <= cse_pkg::raw_value(r1_data, r1_fix.high, r1_fix.low);

            r3_tag   <= r2_tag;
            r3_fault <= r2_fault;
            r3_last  <= r2_last;
            r3_plo   <= 48'(r2_gain[31:0]) * 48'(r2_raw);
            r3_phi   <= (HI_W+17)'(w_ghi) * $signed({1'b0, r2_raw});
            r3_off   <= r2_off;

            r4_tag   <= r3_tag;
            r4_fault <= r3_fault;
            r4_last  <= r3_last;
            r4_acc   <= n_acc;

            r_tag    <= r4_tag;
            r_fault  <= r4_fault;
            r_last   <= r4_last;
            r_sat    <= !w_fits;
            if (w_fits) begin
                r_value <= r4_acc[VW-1:0];
            end else begin
                r_value <= r4_acc[ACC_W-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
            end
        end
    end

    assign o_vld   = r_vld;
    assign o_tag   = r_tag;
    assign o_value = r_value;
    assign o_sat   = r_sat;
    assign o_fault = r_fault;
    assign o_last  = r_last;
endmodule

/* hw/rtl/can_signal_extract_scale_core.sv */
// Top level: ring of entry cells, gain divider, offset multiply and result pipeline.
// Load item: divider yields one gain bit per cycle, then offset and slot write; no result.
// Frame item: ring rotates NUM_ENTRIES steps, one entry at the head per unstalled cycle;
// head matches enter the result pipeline; a new item is taken once the ring has turned.
// Output stalls freeze the ring and the pipeline together.
// Reset clears state and the valid bits; entry contents stay unset until loaded.
module can_signal_extract_scale_core #(
    parameter int NUM_ENTRIES = cse_pkg::NUM_ENTRIES_DEF,
    parameter int FRAC_BITS   = cse_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cse_in_if.sink      i_in,
    cse_out_if.source   o_out
);
    localparam int GAIN_W = 33 + FRAC_BITS;
    localparam int OFF_W  = 50 + FRAC_BITS;
    localparam int ACC_W  = 51 + FRAC_BITS;
    localparam int NUM_W  = 32 + FRAC_BITS;
    localparam int HI_W   = GAIN_W - 32;
    localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_MUL  = 5'b00100,
        S_OFF  = 5'b01000,
        S_ROT  = 5'b10000
    } t_state;

    t_state                         r_state, n_state;
    logic [CNT_W-1:0]               r_cnt;
    logic [cse_pkg::DATA_W-1:0]     r_payload;
    logic [cse_pkg::SLOT_W-1:0]     r_slot;
    cse_pkg::t_entry_fix            r_fix;
    logic [cse_pkg::RAWIN_W-1:0]    r_in_lo;
    logic signed [cse_pkg::OUTE_W-1:0] r_out_lo;
    logic                           r_neg;
    logic signed [GAIN_W-1:0]       r_gain;
    logic [47:0]                    r_qlo;
    logic signed [HI_W+16:0]        r_qhi;

    logic                           w_acc, w_frame, w_load_acc;
    logic                           w_en, w_rot, w_load_en;
    logic signed [16:0]             w_din;
    logic signed [32:0]             w_dout;
    logic [NUM_W-1:0]               w_num;
    logic [15:0]                    w_den;
    logic                           w_div_done;
    logic [NUM_W-1:0]               w_quot;
    logic signed [GAIN_W-1:0]       w_qs;
    logic signed [OFF_W-1:0]        w_offset, w_base, w_prod;
    logic signed [HI_W-1:0]         w_ghi;
    logic                           w_others, w_head_vld;

    logic                           w_valid [NUM_ENTRIES];
    logic                           w_match [NUM_ENTRIES];
    cse_pkg::t_entry_fix            w_fix   [NUM_ENTRIES];
    logic signed [GAIN_W-1:0]       w_gain  [NUM_ENTRIES];
    logic signed [OFF_W-1:0]        w_off   [NUM_ENTRIES];

    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_frame    = w_acc && (i_in.kind == cse_pkg::KIND_FRAME);
    assign w_load_acc = w_acc && (i_in.kind == cse_pkg::KIND_LOAD);
    assign w_en       = !o_out.valid || o_out.ready;
    assign w_rot      = (r_state == S_ROT) && w_en;
    assign w_load_en  = (r_state == S_OFF);

    always_comb begin
        w_din  = $signed({1'b0, i_in.in_high}) - $signed({1'b0, i_in.in_low});
        w_dout = 33'(i_in.out_high) - 33'(i_in.out_low);
        w_num  = NUM_W'(w_dout[32] ? 33'(-w_dout) : w_dout) << FRAC_BITS;
        w_den  = 16'(w_din[16] ? 17'(-w_din) : w_din);
    end

    cse_div #(.NUM_W(NUM_W), .DEN_W(16)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_load_acc),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_qs  = $signed({1'b0, w_quot});
    assign w_ghi = r_gain[GAIN_W-1:32];

    always_comb begin
        w_base   = OFF_W'(r_out_lo) <<< FRAC_BITS;
        w_prod   = (OFF_W'(r_qhi) <<< 32) + OFF_W'({1'b0, r_qlo});
        w_offset = w_base - w_prod;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_load_acc) n_state = S_DIV;
                else if (w_frame) n_state = S_ROT;
            end
            S_DIV: if (w_div_done) n_state = S_MUL;
            S_MUL: n_state = S_OFF;
            S_OFF: n_state = S_IDLE;
            S_ROT: if (w_rot && r_cnt == CNT_W'(NUM_ENTRIES - 1)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_frame) r_cnt <= '0;
            else if (w_rot) r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_frame) r_payload <= i_in.payload;
        if (w_load_acc) begin
            r_slot       <= i_in.slot;
            r_fix.id     <= i_in.frame_id;
            r_fix.mux    <= i_in.mux_spec;
            r_fix.high   <= i_in.high_spec;
            r_fix.low    <= i_in.low_spec;
            r_fix.tag    <= i_in.curve_tag;
            r_fix.fault  <= (w_din == '0);
            r_in_lo      <= i_in.in_low;
            r_out_lo     <= i_in.out_low;
            r_neg        <= w_dout[32] ^ w_din[16];
        end
        if (w_div_done) begin
            if (r_fix.fault) r_gain <= '0;
            else r_gain <= r_neg ? -w_qs : w_qs;
        end
        if (r_state == S_MUL) begin
            r_qlo <= 48'(r_gain[31:0]) * 48'(r_in_lo);
            r_qhi <= (HI_W+17)'(w_ghi) * $signed({1'b0, r_in_lo});
        end
    end

    for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
        localparam int NB = (g + 1) % NUM_ENTRIES;
        logic w_ld;
        if (g < (1 << cse_pkg::SLOT_W)) begin : g_ld
            assign w_ld = w_load_en && (r_slot == cse_pkg::SLOT_W'(g));
        end else begin : g_nold
            assign w_ld = 1'b0;
        end
        cse_cell #(.GAIN_W(GAIN_W), .OFF_W(OFF_W)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (w_ld),
            .i_rot      (w_rot),
            .i_probe    (w_frame),
            .i_fid      (i_in.frame_id),
            .i_byte0    (i_in.payload[7:0]),
            .i_ld_fix   (r_fix),
            .i_ld_gain  (r_gain),
            .i_ld_off   (w_offset),
            .i_nb_valid (w_valid[NB]),
            .i_nb_match ((g == NUM_ENTRIES - 1) ? 1'b0 : w_match[NB]),
            .i_nb_fix   (w_fix[NB]),
            .i_nb_gain  (w_gain[NB]),
            .i_nb_off   (w_off[NB]),
            .o_valid    (w_valid[g]),
            .o_match    (w_match[g]),
            .o_fix      (w_fix[g]),
            .o_gain     (w_gain[g]),
            .o_off      (w_off[g])
        );
    end

    always_comb begin
        w_others = 1'b0;
        for (int k = 1; k < NUM_ENTRIES; k++) begin
            w_others = w_others | w_match[k];
        end
    end

    assign w_head_vld = (r_state == S_ROT) && w_match[0];

    cse_pipe #(.GAIN_W(GAIN_W), .OFF_W(OFF_W), .ACC_W(ACC_W)) u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_vld     (w_head_vld),
        .i_fix     (w_fix[0]),
        .i_gain    (w_gain[0]),
        .i_off     (w_off[0]),
        .i_last    (!w_others),
        .i_payload (r_payload),
        .o_vld     (o_out.valid),
        .o_tag     (o_out.result_tag),
        .o_value   (o_out.value),
        .o_sat     (o_out.saturated),
        .o_fault   (o_out.range_fault),
        .o_last    (o_out.last)
    );

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_no_load_in_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROT |-> !w_load_en)
        else $error("table write during a frame");

    a_idle_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !w_match[0] && !w_others)
        else $error("match left pending after the ring turned");

    a_frame_rotates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_frame |=> r_state == S_ROT && r_cnt == '0)
        else $error("frame did not start the ring");
endmodule

/* tb/sv/tb_cse_checker.sv */
// Checker: watches both item channels, predicts decoded signal values and compares them.
`timescale 1ns / 1ps
module tb_cse_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cse_in_if.sink    i_mon_in,
    cse_out_if.sink   i_mon_out,
    output int        o_fail_count,
    output int        o_pending
);
    typedef struct {
        logic [cse_pkg::TAG_W-1:0] tag;
        logic [cse_pkg::VAL_W-1:0] value;
        logic                      saturated;
        logic                      range_fault;
        logic                      last;
    } t_decoded;

    logic                          sig_valid [cse_pkg::NUM_ENTRIES_DEF];
    logic [cse_pkg::ID_W-1:0]      sig_id    [cse_pkg::NUM_ENTRIES_DEF];
    logic [cse_pkg::MUX_W-1:0]     sig_mux   [cse_pkg::NUM_ENTRIES_DEF];
    logic [cse_pkg::HSPEC_W-1:0]   sig_hspec [cse_pkg::NUM_ENTRIES_DEF];
    logic [cse_pkg::LSPEC_W-1:0]   sig_lspec [cse_pkg::NUM_ENTRIES_DEF];
    logic [cse_pkg::TAG_W-1:0]     sig_tag   [cse_pkg::NUM_ENTRIES_DEF];
    logic signed [63:0]            sig_gain  [cse_pkg::NUM_ENTRIES_DEF];
    logic signed [127:0]           sig_offset[cse_pkg::NUM_ENTRIES_DEF];
    logic                          sig_fault [cse_pkg::NUM_ENTRIES_DEF];
    t_decoded                      decoded_q[$];
    int                            fail_cnt;

    assign o_fail_count = fail_cnt;
    assign o_pending    = decoded_q.size();

    function automatic int bits_of(input logic [8:0] spec);
        return (spec[2:0] >= spec[5:3]) ? int'(spec[2:0]) - int'(spec[5:3]) + 1 : 0;
    endfunction

    function automatic logic [15:0] bits_at(input logic [63:0] data, input logic [8:0] spec);
        logic [7:0] b;
        b = data[8*spec[8:6] +: 8];
        return 16'((b >> spec[5:3]) & ((16'd1 << bits_of(spec)) - 16'd1));
    endfunction

    task automatic learn_signal();
        logic signed [63:0]  din;
        logic signed [63:0]  lo_out;
        logic signed [63:0]  hi_out;
        logic signed [63:0]  gain;
        int s;
        s      = int'(i_mon_in.slot);
        din    = $signed({48'd0, i_mon_in.in_high}) - $signed({48'd0, i_mon_in.in_low});
        lo_out = 64'(i_mon_in.out_low);
        hi_out = 64'(i_mon_in.out_high);
        gain   = (din != 0) ? ((hi_out - lo_out) * 64'sd65536) / din : 64'sd0;
        sig_valid[s]  = 1'b1;
        sig_id[s]     = i_mon_in.frame_id;
        sig_mux[s]    = i_mon_in.mux_spec;
        sig_hspec[s]  = i_mon_in.high_spec;
        sig_lspec[s]  = i_mon_in.low_spec;
        sig_tag[s]    = i_mon_in.curve_tag;
        sig_gain[s]   = gain;
        sig_fault[s]  = (din == 0);
        sig_offset[s] = 128'(lo_out) * 128'sd65536
                      - 128'(gain) * $signed({112'd0, i_mon_in.in_low});
    endtask

    task automatic decode_frame();
        logic [15:0]         hv;
        logic [15:0]         raw;
        logic signed [127:0] acc;
        t_decoded            d;
        int                  n;
        n = 0;
        for (int e = 0; e < cse_pkg::NUM_ENTRIES_DEF; e++) begin
            if (!sig_valid[e] || sig_id[e] != i_mon_in.frame_id) continue;
            if (sig_mux[e][8] && i_mon_in.payload[7:0] != sig_mux[e][7:0]) continue;
            hv  = sig_hspec[e][9] ? bits_at(i_mon_in.payload, sig_hspec[e][8:0]) : 16'd0;
            raw = (hv << bits_of(sig_lspec[e])) + bits_at(i_mon_in.payload, sig_lspec[e]);
            acc = 128'(sig_gain[e]) * $signed({112'd0, raw}) + sig_offset[e];
            d.tag         = sig_tag[e];
            d.range_fault = sig_fault[e];
            d.last        = 1'b0;
            if (acc > 128'sh7FFF_FFFF_FFFF) begin
                d.saturated = 1'b1;
                d.value     = 48'h7FFF_FFFF_FFFF;
            end else if (acc < -128'sh8000_0000_0000) begin
                d.saturated = 1'b1;
                d.value     = 48'h8000_0000_0000;
            end else begin
                d.saturated = 1'b0;
                d.value     = acc[47:0];
            end
            decoded_q.push_back(d);
            n++;
        end
        if (n > 0) decoded_q[$].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_decoded exp_d;
        if (!i_rst_n) begin
            for (int e = 0; e < cse_pkg::NUM_ENTRIES_DEF; e++) sig_valid[e] <= 1'b0;
            fail_cnt <= 0;
        end else begin
            if (i_mon_in.valid && i_mon_in.ready) begin
                if (i_mon_in.kind == cse_pkg::KIND_LOAD) learn_signal();
                else decode_frame();
            end
            if (i_mon_out.valid && i_mon_out.ready) begin
                if (decoded_q.size() == 0) begin
                    $error("result item with nothing expected, tag %h", i_mon_out.result_tag);
                    fail_cnt <= fail_cnt + 1;
                end else begin
                    exp_d = decoded_q.pop_front();
                    if (i_mon_out.result_tag !== exp_d.tag ||
                        i_mon_out.value !== exp_d.value ||
                        i_mon_out.saturated !== exp_d.saturated ||
                        i_mon_out.range_fault !== exp_d.range_fault ||
                        i_mon_out.last !== exp_d.last) begin
                        fail_cnt <= fail_cnt + 1;
                        if (i_mon_out.result_tag !== exp_d.tag)
                            $error("result_tag: expected %h, got %h", exp_d.tag,
                                   i_mon_out.result_tag);
                        if (i_mon_out.value !== exp_d.value)
                            $error("value: expected %h, got %h", exp_d.value,
                                   i_mon_out.value);
                        if (i_mon_out.saturated !== exp_d.saturated)
                            $error("saturated: expected %b, got %b", exp_d.saturated,
                                   i_mon_out.saturated);
                        if (i_mon_out.range_fault !== exp_d.range_fault)
                            $error("range_fault: expected %b, got %b", exp_d.range_fault,
                                   i_mon_out.range_fault);
                        if (i_mon_out.last !== exp_d.last)
                            $error("last: expected %b, got %b", exp_d.last,
                                   i_mon_out.last);
                    end
                end
            end
        end
    end
endmodule

/* tb/sv/tb.sv */
// Testbench top: drives load and frame items into the signal scaler and gives the verdict.
`timescale 1ns / 1ps
module tb;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles;
    logic [cse_pkg::ID_W-1:0] id_pool [4];

    cse_in_if  in_ch ();
    cse_out_if out_ch ();

    can_signal_extract_scale_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    tb_cse_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mon_in    (in_ch.sink),
        .i_mon_out   (out_ch.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls
    always @(negedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else if (r < 8) out_ch.ready <= 1'b0;
        else if (r < 70 || cycles % 2000 < 600) out_ch.ready <= 1'b1;
        else out_ch.ready <= 1'b0;
    end

    // valid stays high after an item until the next call drops it or sends again
    task automatic send(input logic k, input logic [3:0] s,
                        input logic [cse_pkg::ID_W-1:0] fid,
                        input logic [63:0] pl, input logic [8:0] mx, input logic [9:0] hs,
                        input logic [8:0] ls, input logic [15:0] il, input logic [15:0] ih,
                        input logic [31:0] ol, input logic [31:0] oh,
                        input logic [15:0] tg);
        int g;
        g = (cycles % 3000 < 700) ? 0 : gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_ch.kind      <= k;
        in_ch.slot      <= s;
        in_ch.frame_id  <= fid;
        in_ch.payload   <= pl;
        in_ch.mux_spec  <= mx;
        in_ch.high_spec <= hs;
        in_ch.low_spec  <= ls;
        in_ch.in_low    <= il;
        in_ch.in_high   <= ih;
        in_ch.out_low   <= ol;
        in_ch.out_high  <= oh;
        in_ch.curve_tag <= tg;
        in_ch.valid     <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic rand_load(input logic [3:0] s);
        logic [15:0] il;
        logic [15:0] ih;
        int r;
        r  = $urandom_range(0, 9);
        il = 16'($urandom());
        ih = (r == 0) ? il : (r < 3 ? il + 16'($urandom_range(1, 3)) : 16'($urandom()));
        send(cse_pkg::KIND_LOAD, s, id_pool[$urandom_range(0, 3)], rand64(),
             ($urandom_range(0, 2) == 0) ? {1'b1, 8'($urandom_range(0, 3))} : 9'($urandom()),
             10'($urandom()), 9'($urandom()), il, ih,
             ($urandom_range(0, 4) == 0) ? 32'h8000_0000 : $urandom(),
             ($urandom_range(0, 4) == 0) ? 32'h7FFF_FFFF : $urandom(), 16'($urandom()));
    endtask

    task automatic rand_frame();
        logic [63:0] pl;
        logic [cse_pkg::ID_W-1:0] fid;
        logic [31:0] rnd;
        pl = rand64();
        if ($urandom_range(0, 1)) pl[7:0] = 8'($urandom_range(0, 3));
        rnd = $urandom();
        fid = ($urandom_range(0, 9) == 0) ? rnd[cse_pkg::ID_W-1:0]
                                          : id_pool[$urandom_range(0, 3)];
        send(cse_pkg::KIND_FRAME, 4'($urandom()), fid, pl, 9'($urandom()), 10'($urandom()),
             9'($urandom()), 16'($urandom()), 16'($urandom()), $urandom(), $urandom(),
             16'($urandom()));
    endtask

    initial begin
        cycles          = 0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = 1'b0;
        in_ch.slot      = '0;
        in_ch.frame_id  = '0;
        in_ch.payload   = '0;
        in_ch.mux_spec  = '0;
        in_ch.high_spec = '0;
        in_ch.low_spec  = '0;
        in_ch.in_low    = '0;
        in_ch.in_high   = '0;
        in_ch.out_low   = '0;
        in_ch.out_high  = '0;
        in_ch.curve_tag = '0;
        out_ch.ready    = 1'b0;
        id_pool[0] = 29'h1FFF_FFFF;
        id_pool[1] = 29'h0;
        id_pool[2] = 29'h0AB_CDEF;
        id_pool[3] = 29'h123;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // frame into an empty table
        send(cse_pkg::KIND_FRAME, 0, id_pool[0], '1, '0, '0, '0, 0, 0, 0, 0, 0);
        // extreme ranges, equal range ends, reversed bit range, mux on and off
        send(cse_pkg::KIND_LOAD, 0, id_pool[0], '0, 9'h000, 10'h3FF, 9'h1FF, 16'h0, 16'hFFFF,
             32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        send(cse_pkg::KIND_LOAD, 1, id_pool[0], '0, 9'h1FF, 10'h207, 9'h038, 16'h1234,
             16'h1234, 32'h7FFF_FFFF, 32'h0, 16'h0001);
        send(cse_pkg::KIND_LOAD, 2, id_pool[0], '0, 9'h100, 10'h23F, 9'h1C7, 16'hFFFF, 16'h0,
             32'h7FFF_FFFF, 32'h8000_0000, 16'h0002);
        send(cse_pkg::KIND_LOAD, 15, id_pool[0], '0, 9'h0, 10'h000, 9'h07, 16'h1, 16'h0,
             32'h7FFF_FFFF, 32'h8000_0000, 16'hA5A5);
        send(cse_pkg::KIND_LOAD, 3, id_pool[1], '0, 9'h0, 10'h1C0, 9'h000, 16'h0, 16'h1,
             32'h0, 32'h1, 16'h0003);
        send(cse_pkg::KIND_FRAME, 0, id_pool[0], 64'hFFFF_FFFF_FFFF_FFFF,
             0, 0, 0, 0, 0, 0, 0, 0);
        send(cse_pkg::KIND_FRAME, 0, id_pool[0], 64'h0000_0000_0000_0000,
             0, 0, 0, 0, 0, 0, 0, 0);
        send(cse_pkg::KIND_FRAME, 0, id_pool[0], 64'h8000_0000_0000_00FF,
             0, 0, 0, 0, 0, 0, 0, 0);
        send(cse_pkg::KIND_FRAME, 0, id_pool[0], 64'h5555_AAAA_0F0F_F000,
             0, 0, 0, 0, 0, 0, 0, 0);
        send(cse_pkg::KIND_FRAME, 0, id_pool[1], 64'hFFFF_FFFF_FFFF_FFFF,
             0, 0, 0, 0, 0, 0, 0, 0);
        send(cse_pkg::KIND_FRAME, 0, id_pool[2], 64'h1, 0, 0, 0, 0, 0, 0, 0, 0);
        // fill every slot with the same id so one frame gives sixteen results
        for (int s = 0; s < cse_pkg::NUM_ENTRIES_DEF; s++)
            send(cse_pkg::KIND_LOAD, 4'(s), id_pool[3], '0, 9'h0, 10'($urandom()),
                 9'($urandom()), 16'($urandom()), 16'($urandom()), $urandom(), $urandom(),
                 16'(s));
        send(cse_pkg::KIND_FRAME, 0, id_pool[3], rand64(), 0, 0, 0, 0, 0, 0, 0, 0);

        for (int n = 0; n < 400; n++) begin
            if ($urandom_range(0, 3) == 0) rand_load(4'($urandom()));
            else rand_frame();
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/cse_pkg.sv
hw/rtl/cse_if.sv
hw/rtl/cse_div.sv
hw/rtl/cse_cell.sv
hw/rtl/cse_pipe.sv
hw/rtl/can_signal_extract_scale_core.sv
tb/sv/tb_cse_checker.sv
tb/sv/tb.sv
